// ----- sv/pori_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pori_pkg
// Shared widths, operation and status codes, and the command and flag
// bundles passed between the list controller and its datapath.
// ----------------------------------------------------------------------------
package pori_pkg;

  localparam int unsigned MaxItemsDef = 32;

  localparam int unsigned KindW     = 2;
  localparam int unsigned ItemIdW   = 5;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CountOutW = 6;

  typedef enum logic [KindW-1:0] {
    KIND_SORTED = 2'd0,
    KIND_HEAD   = 2'd1,
    KIND_TAIL   = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_LIMIT  = 2'd1,
    STATUS_ABSENT = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    set_status;
    status_e status;
    logic    empty_insert;
    logic    unlink;
    logic    drop_last;
    logic    capture;
    logic    at_cur;
    logic    new_head;
    logic    walk_first;
    logic    walk_step;
    logic    link_a;
    logic    link_b;
    logic    load_result;
  } pori_cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  over_limit;
    logic  member;
    logic  empty;
    logic  single;
    logic  value_le;
    logic  walk_end;
    logic  out_free;
  } pori_flags_t;

endpackage

// ----- sv/pori_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pori_ctrl
// Sequencer for one list operation: decode, walk, two link phases and the
// result handoff.
// ----------------------------------------------------------------------------
module pori_ctrl import pori_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pori_flags_t flags_i,
  output pori_cmd_t   cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECODE = 7'b0000010,
    ST_WALK   = 7'b0000100,
    ST_LINK_A = 7'b0001000,
    ST_LINK_B = 7'b0010000,
    ST_RESP   = 7'b0100000,
    ST_SPARE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = STATUS_OK;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.set_status = 1'b1;
        state_d          = ST_RESP;
        if (flags_i.kind == KIND_REMOVE) begin
          if (!flags_i.member) begin
            cmd_o.status = STATUS_ABSENT;
          end else if (flags_i.single) begin
            cmd_o.drop_last = 1'b1;
          end else begin
            cmd_o.unlink = 1'b1;
          end
        end else if (flags_i.over_limit) begin
          cmd_o.status = STATUS_LIMIT;
        end else if (flags_i.member) begin
          cmd_o.status = STATUS_OK;
        end else if (flags_i.empty) begin
          cmd_o.empty_insert = 1'b1;
        end else if (flags_i.kind == KIND_SORTED) begin
          // first entry already read at the head
          if (flags_i.value_le) begin
            cmd_o.capture  = 1'b1;
            cmd_o.new_head = 1'b1;
            state_d        = ST_LINK_A;
          end else begin
            cmd_o.walk_first = 1'b1;
            state_d          = ST_WALK;
          end
        end else begin
          cmd_o.capture  = 1'b1;
          cmd_o.new_head = (flags_i.kind == KIND_HEAD);
          state_d        = ST_LINK_A;
        end
      end
      ST_WALK: begin
        if (flags_i.walk_end || flags_i.value_le) begin
          cmd_o.capture = 1'b1;
          cmd_o.at_cur  = 1'b1;
          state_d       = ST_LINK_A;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      ST_LINK_A: begin
        cmd_o.link_a = 1'b1;
        state_d      = ST_LINK_B;
      end
      ST_LINK_B: begin
        cmd_o.link_b = 1'b1;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        if (flags_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/pori_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pori_datapath
// Link and value memories, membership flags, head and count registers, the
// walk pointer and the result register.
// ----------------------------------------------------------------------------
module pori_datapath import pori_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MaxItemsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [KindW-1:0]     kind_i,
  input  logic [ItemIdW-1:0]   item_id_i,
  input  logic [ValueW-1:0]    order_value_i,
  input  logic                 cfg_we_i,
  input  logic [ValueW-1:0]    cfg_wdata_i,
  input  logic                 out_ready_i,
  input  pori_cmd_t            cmd_i,
  output pori_flags_t          flags_o,
  output logic                 out_valid_o,
  output logic [StatusW-1:0]   status_o,
  output logic [CountOutW-1:0] entry_count_o,
  output logic [ItemIdW-1:0]   head_item_o,
  output logic                 list_empty_o
);

  localparam int unsigned IW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  // item number to pool slot
  logic [IW-1:0] slot_tab [2**ItemIdW];
  for (genvar g = 0; g < 2**ItemIdW; g++) begin : g_slot
    localparam logic [IW-1:0] SlotOf = IW'(g % MAX_ITEMS);
    assign slot_tab[g] = SlotOf;
  end

  kind_e                kind_q;
  logic [IW-1:0]        slot_q;
  logic [ValueW-1:0]    value_q;
  logic [IW-1:0]        cur_q;
  logic [CW-1:0]        idx_q;
  logic [IW-1:0]        at_q;
  logic [IW-1:0]        before_q;
  logic                 new_head_q;
  status_e              status_q;

  logic [ValueW-1:0]    limit_q;
  logic [IW-1:0]        head_q;
  logic [CW-1:0]        count_q;
  logic [MAX_ITEMS-1:0] member_q;

  logic                 out_valid_q;
  logic [StatusW-1:0]   out_status_q;
  logic [CountOutW-1:0] out_count_q;
  logic [ItemIdW-1:0]   out_head_q;
  logic                 out_empty_q;

  logic [IW-1:0]        next_mem [MAX_ITEMS];
  logic [IW-1:0]        prev_mem [MAX_ITEMS];
  logic [ValueW-1:0]    value_mem [MAX_ITEMS];
  logic [IW-1:0]        next_rd_q;
  logic [IW-1:0]        prev_rd_q;
  logic [ValueW-1:0]    value_rd_q;

  logic [IW-1:0]        rd_addr;
  logic                 nxt_we, prv_we, val_we;
  logic [IW-1:0]        nxt_waddr, nxt_wdata, prv_waddr, prv_wdata, val_waddr;

  // read address follows the walk, else the entry the new transaction needs
  always_comb begin
    if (cmd_i.walk_first || cmd_i.walk_step) begin
      rd_addr = next_rd_q;
    end else if (kind_e'(kind_i) == KIND_REMOVE) begin
      rd_addr = slot_tab[item_id_i];
    end else begin
      rd_addr = head_q;
    end
  end

  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = slot_q;
    nxt_wdata = slot_q;
    prv_we    = 1'b0;
    prv_waddr = slot_q;
    prv_wdata = slot_q;
    val_we    = 1'b0;
    val_waddr = slot_q;
    if (cmd_i.empty_insert) begin
      nxt_we = 1'b1;
      prv_we = 1'b1;
      val_we = 1'b1;
    end
    if (cmd_i.unlink) begin
      prv_we    = 1'b1;
      prv_waddr = next_rd_q;
      prv_wdata = prev_rd_q;
      nxt_we    = 1'b1;
      nxt_waddr = prev_rd_q;
      nxt_wdata = next_rd_q;
    end
    if (cmd_i.link_a) begin
      nxt_we    = 1'b1;
      nxt_wdata = at_q;
      prv_we    = 1'b1;
      prv_wdata = before_q;
      val_we    = 1'b1;
    end
    if (cmd_i.link_b) begin
      nxt_we    = 1'b1;
      nxt_waddr = before_q;
      prv_we    = 1'b1;
      prv_waddr = at_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      next_mem[nxt_waddr] <= nxt_wdata;
    end
    next_rd_q <= next_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (prv_we) begin
      prev_mem[prv_waddr] <= prv_wdata;
    end
    prev_rd_q <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      value_mem[val_waddr] <= value_q;
    end
    value_rd_q <= value_mem[rd_addr];
  end

  // transaction payload and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q  <= kind_e'(kind_i);
      slot_q  <= slot_tab[item_id_i];
      value_q <= order_value_i;
    end
    if (cmd_i.walk_first) begin
      cur_q <= next_rd_q;
      idx_q <= CW'(1);
    end else if (cmd_i.walk_step) begin
      cur_q <= next_rd_q;
      idx_q <= idx_q + CW'(1);
    end
    if (cmd_i.capture) begin
      at_q       <= cmd_i.at_cur ? cur_q : head_q;
      before_q   <= prev_rd_q;
      new_head_q <= cmd_i.new_head;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.load_result) begin
      out_status_q <= status_q;
      out_count_q  <= CountOutW'(count_q);
      out_head_q   <= ItemIdW'(head_q);
      out_empty_q  <= (count_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= '1;
      head_q      <= '0;
      count_q     <= '0;
      member_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.empty_insert) begin
        head_q           <= slot_q;
        count_q          <= count_q + CW'(1);
        member_q[slot_q] <= 1'b1;
      end
      if (cmd_i.link_b) begin
        if (new_head_q) begin
          head_q <= slot_q;
        end
        count_q          <= count_q + CW'(1);
        member_q[slot_q] <= 1'b1;
      end
      if (cmd_i.unlink) begin
        if (head_q == slot_q) begin
          head_q <= next_rd_q;
        end
        count_q          <= count_q - CW'(1);
        member_q[slot_q] <= 1'b0;
      end
      if (cmd_i.drop_last) begin
        head_q           <= '0;
        count_q          <= '0;
        member_q[slot_q] <= 1'b0;
      end
      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign flags_o.kind       = kind_q;
  assign flags_o.over_limit = (value_q > limit_q);
  assign flags_o.member     = member_q[slot_q];
  assign flags_o.empty      = (count_q == '0);
  assign flags_o.single     = (count_q == CW'(1));
  assign flags_o.value_le   = (value_q <= value_rd_q);
  assign flags_o.walk_end   = (idx_q >= count_q);
  assign flags_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;
  assign head_item_o   = out_head_q;
  assign list_empty_o  = out_empty_q;

endmodule

// ----- sv/priority_ordered_item_list_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ordered_item_list_core
// Sorted circular doubly linked list over a fixed pool of item slots.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid_i / in_ready_o) carries one operation per
//   transaction: kind_i (sorted insert, head insert, tail insert, remove),
//   item_id_i and order_value_i. One operation is worked on at a time;
//   in_ready_o is high only while the sequencer is idle.
//   output channel (out_valid_o / out_ready_i) returns one result per
//   operation: status, entry count, head item and empty flag.
//   cfg_we_i writes value_limit from cfg_wdata_i; write only while idle.
// States from acceptance to out_valid_o:
//   remove, rejected or duplicate insert, insert into empty list: DECODE, RESP
//   head or tail insert, sorted insert at head: DECODE, LINK_A, LINK_B, RESP
//   sorted insert after k walked entries, k up to the count: adds WALK
// The walk reads one entry per cycle from the link and value memories.
// Reset empties the list and sets value_limit to all ones; link and value
// memories are not cleared. A stalled receiver holds the result register
// and the next operation waits in the final step until the result is taken.
// ----------------------------------------------------------------------------
module priority_ordered_item_list_core import pori_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MaxItemsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [KindW-1:0]     kind_i,
  input  logic [ItemIdW-1:0]   item_id_i,
  input  logic [ValueW-1:0]    order_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [StatusW-1:0]   status_o,
  output logic [CountOutW-1:0] entry_count_o,
  output logic [ItemIdW-1:0]   head_item_o,
  output logic                 list_empty_o,
  input  logic                 cfg_we_i,
  input  logic [ValueW-1:0]    cfg_wdata_i
);

  pori_cmd_t   cmd;
  pori_flags_t flags;

  pori_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  pori_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_i),
    .item_id_i     (item_id_i),
    .order_value_i (order_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_ready_i   (out_ready_i),
    .cmd_i         (cmd),
    .flags_o       (flags),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .head_item_o   (head_item_o),
    .list_empty_o  (list_empty_o)
  );

endmodule

// ----- sv/pori_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pori_checker
// Port-level checks for the priority ordered item list, bound to the top.
// ----------------------------------------------------------------------------
module pori_checker import pori_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MaxItemsDef
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [KindW-1:0]     kind_i,
  input logic [ItemIdW-1:0]   item_id_i,
  input logic [ValueW-1:0]    order_value_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [StatusW-1:0]   status_o,
  input logic [CountOutW-1:0] entry_count_o,
  input logic [ItemIdW-1:0]   head_item_o,
  input logic                 list_empty_o,
  input logic                 cfg_we_i,
  input logic [ValueW-1:0]    cfg_wdata_i
);

  // result stays offered until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one transaction in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // no result appears without an operation working on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result raised from idle");

  // empty flag agrees with the count and the count fits the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (list_empty_o == (entry_count_o == '0)) &&
                    (32'(entry_count_o) <= MAX_ITEMS))
    else $error("inconsistent result");

  // reset empties the result register
  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind priority_ordered_item_list_core pori_checker #(
  .MAX_ITEMS (MAX_ITEMS)
) u_pori_checker (.*);
